// ===== rtl/hsv_to_rgb_rainbow_core_defines.svh =====
// Assertion macros shared by the rainbow HSV to RGB converter.
`ifndef HSV_TO_RGB_RAINBOW_CORE_DEFINES_SVH
`define HSV_TO_RGB_RAINBOW_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsvr_pkg.sv =====
// Types, constants and helper functions of the rainbow HSV to RGB converter.
package hsvr_pkg;

    localparam int unsigned CHAN_W = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;
    localparam logic [CHAN_W-1:0] THIRD_SCALE      = 8'(256 / 3);
    localparam logic [CHAN_W-1:0] TWO_THIRDS_SCALE = 8'((256 * 2) / 3);
    localparam logic [CHAN_W-1:0] LEVEL_85         = 8'd85;
    localparam logic [CHAN_W-1:0] LEVEL_170        = 8'd170;
    localparam logic [CHAN_W-1:0] LEVEL_171        = 8'd171;

    // Hue sections picked by the three top hue bits.
    localparam logic [2:0] SEC_RED_ORANGE    = 3'd0;
    localparam logic [2:0] SEC_ORANGE_YELLOW = 3'd1;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd2;
    localparam logic [2:0] SEC_GREEN_AQUA    = 3'd3;
    localparam logic [2:0] SEC_AQUA_BLUE     = 3'd4;
    localparam logic [2:0] SEC_BLUE_PURPLE   = 3'd5;
    localparam logic [2:0] SEC_PURPLE_PINK   = 3'd6;
    localparam logic [2:0] SEC_PINK_RED      = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } hsvr_rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] hue;
    } hsvr_hsv_t;

    // After the hue stage: base color plus everything the later stages need.
    typedef struct packed {
        hsvr_rgb_t         color;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] floor_level;
        logic              val_full;
        logic [CHAN_W-1:0] level;
    } hsvr_s1_t;

    // After the saturation stage.
    typedef struct packed {
        hsvr_rgb_t         color;
        logic              val_full;
        logic [CHAN_W-1:0] level;
    } hsvr_s2_t;

    // Fixed scale: (x * (s + 1)) >> 8.
    function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] x,
                                                 input logic [CHAN_W-1:0] s);
        logic [2*CHAN_W:0] prod;
        begin
            prod = {{(CHAN_W+1){1'b0}}, x} * ({1'b0, s} + {{CHAN_W{1'b0}}, 1'b1});
            return prod[2*CHAN_W-1:CHAN_W];
        end
    endfunction

endpackage

// ===== rtl/hsvr_hue.sv =====
// First pipeline stage: rainbow hue map, desaturation floor and squared value.
module hsvr_hue
    import hsvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hsvr_hsv_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hsvr_s1_t  out_data
);

    logic              valid_reg;
    logic              valid_next;
    hsvr_s1_t          data_reg;
    hsvr_s1_t          data_next;
    logic [CHAN_W-1:0] ramp;
    logic [CHAN_W-1:0] third;
    logic [CHAN_W-1:0] two_thirds;
    logic [CHAN_W-1:0] inv_sat;
    logic [2*CHAN_W-1:0] bright_sq;
    hsvr_rgb_t         base;

    assign ramp       = {in_data.hue[4:0], 3'b000};
    assign third      = scale8(ramp, THIRD_SCALE);
    assign two_thirds = scale8(ramp, TWO_THIRDS_SCALE);
    assign inv_sat    = CHAN_MAX - in_data.saturation;
    assign bright_sq  = {{CHAN_W{1'b0}}, in_data.brightness} *
                        {{CHAN_W{1'b0}}, in_data.brightness};

    always_comb
    begin
        base = '0;
        case (in_data.hue[7:5])
            SEC_RED_ORANGE:
            begin
                base.red   = CHAN_MAX - third;
                base.green = third;
            end
            SEC_ORANGE_YELLOW:
            begin
                base.red   = LEVEL_171;
                base.green = LEVEL_85 + third;
            end
            SEC_YELLOW_GREEN:
            begin
                base.red   = LEVEL_171 - two_thirds;
                base.green = LEVEL_170 + third;
            end
            SEC_GREEN_AQUA:
            begin
                base.green = CHAN_MAX - third;
                base.blue  = third;
            end
            SEC_AQUA_BLUE:
            begin
                base.green = LEVEL_171 - two_thirds;
                base.blue  = LEVEL_85 + two_thirds;
            end
            SEC_BLUE_PURPLE:
            begin
                base.red   = third;
                base.blue  = CHAN_MAX - third;
            end
            SEC_PURPLE_PINK:
            begin
                base.red   = LEVEL_85 + third;
                base.blue  = LEVEL_171 - third;
            end
            SEC_PINK_RED:
            begin
                base.red   = LEVEL_170 + third;
                base.blue  = LEVEL_85 - third;
            end
            default:
            begin
                base = '0;
            end
        endcase
    end

    always_comb
    begin
        data_next.color       = base;
        data_next.saturation  = in_data.saturation;
        data_next.floor_level = scale8(inv_sat, inv_sat);
        data_next.val_full    = (in_data.brightness == CHAN_MAX);
        data_next.level       = bright_sq[2*CHAN_W-1:CHAN_W] +
                                {{(CHAN_W-1){1'b0}}, (in_data.brightness != '0)};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/hsvr_sat.sv =====
// Second pipeline stage: mixes the base color toward white by saturation.
module hsvr_sat
    import hsvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  hsvr_s1_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output hsvr_s2_t out_data
);

    logic     valid_reg;
    logic     valid_next;
    hsvr_s2_t data_reg;
    hsvr_s2_t data_next;

    always_comb
    begin
        data_next.val_full = in_data.val_full;
        data_next.level    = in_data.level;
        if (in_data.saturation == CHAN_MAX)
        begin
            data_next.color = in_data.color;
        end
        else if (in_data.saturation == '0)
        begin
            data_next.color = '{blue: CHAN_MAX, green: CHAN_MAX, red: CHAN_MAX};
        end
        else
        begin
            // The floor add wraps to eight bits.
            data_next.color.red   = scale8(in_data.color.red, in_data.saturation) +
                                    in_data.floor_level;
            data_next.color.green = scale8(in_data.color.green, in_data.saturation) +
                                    in_data.floor_level;
            data_next.color.blue  = scale8(in_data.color.blue, in_data.saturation) +
                                    in_data.floor_level;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/hsvr_val.sv =====
// Third pipeline stage: scales the color toward black by the squared value.
module hsvr_val
    import hsvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hsvr_s2_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hsvr_rgb_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    hsvr_rgb_t data_reg;
    hsvr_rgb_t data_next;

    always_comb
    begin
        if (in_data.val_full)
        begin
            data_next = in_data.color;
        end
        else if (in_data.level == '0)
        begin
            data_next = '0;
        end
        else
        begin
            data_next.red   = scale8(in_data.color.red, in_data.level);
            data_next.green = scale8(in_data.color.green, in_data.level);
            data_next.blue  = scale8(in_data.color.blue, in_data.level);
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/hsv_to_rgb_rainbow_core.sv =====
// Hue map, saturation and value each own one register stage, passed in that order.
// Throughput: one word per cycle while the output takes words.
// Each stage loads whenever it is empty or its successor takes its word, so stalls lose nothing.
// Reset (rst_n, asynchronous, active low) clears the three stage valid bits only.
// There is no configuration and no state carried from one pixel to the next.
`include "hsv_to_rgb_rainbow_core_defines.svh"

module hsv_to_rgb_rainbow_core
    import hsvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red [7:0], green [15:8], blue [23:16]
);

    hsvr_hsv_t in_word;
    hsvr_s1_t  hue_data;
    hsvr_s2_t  sat_data;
    hsvr_rgb_t val_data;
    logic      hue_valid;
    logic      hue_ready;
    logic      sat_valid;
    logic      sat_ready;

    // The input word layout matches the struct, hue in the lowest byte.
    assign in_word.hue        = s_axis_tdata[7:0];
    assign in_word.saturation = s_axis_tdata[15:8];
    assign in_word.brightness = s_axis_tdata[23:16];

    // Stage one looks up the rainbow section and precomputes the
    // desaturation floor and the video-rounded squared brightness.
    hsvr_hue u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_word),
        .out_valid (hue_valid),
        .out_ready (hue_ready),
        .out_data  (hue_data)
    );

    // Stage two applies saturation: white at zero, unchanged at full, scale plus floor otherwise.
    hsvr_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .in_data   (hue_data),
        .out_valid (sat_valid),
        .out_ready (sat_ready),
        .out_data  (sat_data)
    );

    // Stage three applies value and doubles as the output register.
    hsvr_val u_val (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_data   (sat_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (val_data)
    );

    assign m_axis_tdata = {val_data.blue, val_data.green, val_data.red};

    // Back-pressure reaches the input only when every stage holds a word.
    `HSVR_ASSERT_NOW(a_full_when_stalled, !s_axis_tready,
        hue_valid && sat_valid && m_axis_tvalid, "input stalled with a pipeline bubble")

    // A pixel whose squared value rounds to zero leaves as black.
    `HSVR_ASSERT_NEXT(a_black_level, sat_valid && sat_ready && !sat_data.val_full &&
        (sat_data.level == '0), m_axis_tdata == '0, "zero value did not give black")

    // Zero saturation gives white out of the saturation stage, whatever the value.
    `HSVR_ASSERT_NEXT(a_white_full, hue_valid && hue_ready && (hue_data.saturation == '0),
        sat_data.color.red == CHAN_MAX && sat_data.color.green == CHAN_MAX &&
        sat_data.color.blue == CHAN_MAX, "zero saturation did not give white")

endmodule

// ===== tb/hsv_to_rgb_rainbow_core_tb.sv =====
// Self-checking stream testbench for the rainbow HSV to RGB converter core.
`timescale 1ns / 100ps

module hsv_to_rgb_rainbow_core_tb;
    import hsvr_pkg::*;

    // Run shape. The long output hold-off starts once enough input words went in,
    // and the quiet window is a span of input words in which neither side idles.
    localparam int unsigned RANDOM_PIXELS    = 1950;
    localparam int unsigned IDLE_PERCENT     = 10;
    localparam int unsigned QUIET_FROM       = 1200;
    localparam int unsigned QUIET_TO         = 1500;
    localparam int unsigned LONG_HOLD_AT     = 600;
    localparam int unsigned LONG_HOLD_CYCLES = 150;
    localparam int unsigned TAIL_CYCLES      = 10;
    localparam longint      TIMEOUT_NS       = 2_000_000;

    // One pixel in flight: the input word and the color it must turn into.
    typedef struct {
        hsvr_hsv_t pixel;
        hsvr_rgb_t color;
    } pixel_check_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // hue [7:0], saturation [15:8], brightness [23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red [7:0], green [15:8], blue [23:16]

    hsvr_hsv_t    pending_pixels[$];
    pixel_check_t expected_colors[$];

    int unsigned words_in = 0;
    int unsigned error_count = 0;
    bit          in_taken = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    hsv_to_rgb_rainbow_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Fixed-point scale: x * (s + 1) / 256, truncated.
    function automatic logic [7:0] scale_by(input logic [7:0] x, input logic [7:0] s);
        logic [16:0] prod;
        begin
            prod = {9'd0, x} * ({9'd0, s} + 17'd1);
            return prod[15:8];
        end
    endfunction

    // Predicts the color of one pixel: hue map, then saturation, then value.
    function automatic hsvr_rgb_t rainbow_color(input hsvr_hsv_t px);
        logic [7:0]  ramp;
        logic [7:0]  third;
        logic [7:0]  two_thirds;
        logic [7:0]  desat_floor;
        logic [15:0] squared;
        logic [7:0]  level;
        hsvr_rgb_t   c;
        begin
            ramp       = {px.hue[4:0], 3'b000};
            third      = scale_by(ramp, THIRD_SCALE);
            two_thirds = scale_by(ramp, TWO_THIRDS_SCALE);
            c          = '0;
            case (px.hue[7:5])
                SEC_RED_ORANGE:
                begin
                    c.red   = CHAN_MAX - third;
                    c.green = third;
                end
                SEC_ORANGE_YELLOW:
                begin
                    c.red   = LEVEL_171;
                    c.green = LEVEL_85 + third;
                end
                SEC_YELLOW_GREEN:
                begin
                    c.red   = LEVEL_171 - two_thirds;
                    c.green = LEVEL_170 + third;
                end
                SEC_GREEN_AQUA:
                begin
                    c.green = CHAN_MAX - third;
                    c.blue  = third;
                end
                SEC_AQUA_BLUE:
                begin
                    c.green = LEVEL_171 - two_thirds;
                    c.blue  = LEVEL_85 + two_thirds;
                end
                SEC_BLUE_PURPLE:
                begin
                    c.red  = third;
                    c.blue = CHAN_MAX - third;
                end
                SEC_PURPLE_PINK:
                begin
                    c.red  = LEVEL_85 + third;
                    c.blue = LEVEL_171 - third;
                end
                default:
                begin
                    c.red  = LEVEL_170 + third;
                    c.blue = LEVEL_85 - third;
                end
            endcase

            // Saturation mixes toward white; the added floor wraps at 8 bits.
            if (px.saturation == '0)
                c = {CHAN_MAX, CHAN_MAX, CHAN_MAX};
            else if (px.saturation != CHAN_MAX)
            begin
                desat_floor = scale_by(~px.saturation, ~px.saturation);
                c.red   = scale_by(c.red, px.saturation) + desat_floor;
                c.green = scale_by(c.green, px.saturation) + desat_floor;
                c.blue  = scale_by(c.blue, px.saturation) + desat_floor;
            end

            // Value is squared with video rounding, so only zero value gives a zero level.
            if (px.brightness != CHAN_MAX)
            begin
                squared = px.brightness * px.brightness;
                level   = squared[15:8] + ((px.brightness != '0) ? 8'd1 : 8'd0);
                if (level == '0)
                    c = '0;
                else
                begin
                    c.red   = scale_by(c.red, level);
                    c.green = scale_by(c.green, level);
                    c.blue  = scale_by(c.blue, level);
                end
            end
            return c;
        end
    endfunction

    // Either side takes a break now and then, except inside the quiet window.
    function automatic bit take_break(input int unsigned count);
        begin
            if (count >= QUIET_FROM && count < QUIET_TO)
                return 1'b0;
            return $urandom_range(99) < IDLE_PERCENT;
        end
    endfunction

    // Channel levels lean on the corners: zero, full, and their neighbors.
    function automatic logic [7:0] pick_level();
        begin
            case ($urandom_range(15))
                0:       return 8'd0;
                1:       return 8'd255;
                2:       return 8'd1;
                3:       return 8'd254;
                default: return 8'($urandom_range(255));
            endcase
        end
    endfunction

    // Hue is mostly uniform, sometimes pinned to the first or last step of a section.
    function automatic logic [7:0] pick_hue();
        begin
            if ($urandom_range(7) == 0)
                return {3'($urandom_range(7)), {5{1'($urandom_range(1))}}};
            return 8'($urandom_range(255));
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("%0t: mismatch: %s", $time, what);
            error_count++;
        end
    endtask

    task automatic queue_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
        hsvr_hsv_t px;
        begin
            px.hue        = h;
            px.saturation = s;
            px.brightness = v;
            pending_pixels.push_back(px);
        end
    endtask

    // Returns once every queued word went in and every expected color came out.
    task automatic wait_for_drain();
        begin
            while (pending_pixels.size() != 0 || s_axis_tvalid || expected_colors.size() != 0)
                @(posedge clk);
        end
    endtask

    // Input driver. A new word is put up only once the previous one was taken
    // at the last rising edge, so a waiting word and its tvalid hold steady.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (pending_pixels.size() != 0 && !take_break(words_in))
            begin
                s_axis_tdata  <= pending_pixels.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Output ready. Once enough words went in, the receiver holds off for a long
    // stretch so the three stages fill and the core stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && words_in >= LONG_HOLD_AT)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
            m_axis_tready <= !take_break(words_in);
    end

    // Monitor on the rising edge. The output word is checked before the input
    // word of the same edge is predicted, so a stray result cannot hide.
    always @(posedge clk)
    begin
        pixel_check_t head;
        hsvr_rgb_t    got;
        string        names[3];
        names = '{"red", "green", "blue"};
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_colors.size() == 0)
                    report_mismatch($sformatf("output word %h with nothing expected", got));
                else
                begin
                    head = expected_colors.pop_front();
                    for (int ch = 0; ch < 3; ch++)
                        if (got[ch*8 +: 8] != head.color[ch*8 +: 8])
                            report_mismatch($sformatf("hsv %0d/%0d/%0d %s got %0d exp %0d",
                                head.pixel.hue, head.pixel.saturation,
                                head.pixel.brightness, names[ch],
                                got[ch*8 +: 8], head.color[ch*8 +: 8]));
                end
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                head.pixel = s_axis_tdata;
                head.color = rainbow_color(head.pixel);
                expected_colors.push_back(head);
                words_in <= words_in + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: first and last step of every hue section at full color.
        for (int sec = 0; sec < 8; sec++)
        begin
            queue_pixel(8'(sec * 32), 8'd255, 8'd255);
            queue_pixel(8'(sec * 32 + 31), 8'd255, 8'd255);
        end
        // Zero saturation gives white; low and near-full saturation show the desaturation floor.
        queue_pixel(8'd40, 8'd0, 8'd255);
        queue_pixel(8'd100, 8'd1, 8'd255);
        queue_pixel(8'd200, 8'd254, 8'd255);
        // Zero value gives black; small and near-full values use the squared level.
        queue_pixel(8'd70, 8'd255, 8'd0);
        queue_pixel(8'd150, 8'd255, 8'd1);
        queue_pixel(8'd230, 8'd255, 8'd254);
        queue_pixel(8'd128, 8'd128, 8'd128);

        // The sender pauses here until every directed result is back.
        wait_for_drain();

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            queue_pixel(pick_hue(), pick_level(), pick_level());
            if (i == RANDOM_PIXELS / 2)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("hsv_to_rgb_rainbow_core_tb: clean");
        else
            $display("hsv_to_rgb_rainbow_core_tb: errors");
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial
    begin
        #(TIMEOUT_NS);
        $display("hsv_to_rgb_rainbow_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hsvr_pkg.sv
rtl/hsvr_hue.sv
rtl/hsvr_sat.sv
rtl/hsvr_val.sv
rtl/hsv_to_rgb_rainbow_core.sv
tb/hsv_to_rgb_rainbow_core_tb.sv
